// ===== sv/rarmt_pkg.sv =====
`timescale 1ns / 1ps

package rarmt_pkg;

    // Default number of array elements that the tree can hold.
    localparam int MAX_ELEMENTS_DEF = 1024;

    // Fixed field widths of the request and response channels.
    localparam int START_W  = 10;
    localparam int END_W    = 11;
    localparam int AMOUNT_W = 32;
    localparam int VALUE_W  = 64;
    localparam int LENGTH_W = 11;

    // Value returned for an empty span.
    localparam logic signed [VALUE_W-1:0] MOST_POSITIVE = {1'b0, {(VALUE_W-1){1'b1}}};

    // Request modes.
    localparam logic MODE_ADD   = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_VISIT,
        ST_NODE,
        ST_PD_L,
        ST_PD_R,
        ST_PD_N,
        ST_CH_L,
        ST_CH_R,
        ST_DONE
    } state_t;

    // Progress of one stacked tree node.
    typedef enum logic [1:0] {
        PH_ENTER,
        PH_RIGHT,
        PH_JOIN
    } phase_t;

endpackage

// ===== sv/rarmt_if.sv =====
`timescale 1ns / 1ps

// Request channel: one add or query request.
interface rarmt_req_if;
    logic                                        valid;
    logic                                        ready;
    logic                                        mode;
    logic        [rarmt_pkg::START_W-1:0]        range_start;
    logic        [rarmt_pkg::END_W-1:0]          range_end;
    logic signed [rarmt_pkg::AMOUNT_W-1:0]       add_amount;

    modport source (output valid, mode, range_start, range_end, add_amount, input ready);
    modport sink   (input valid, mode, range_start, range_end, add_amount, output ready);
endinterface

// Response channel: the minimum of a query.
interface rarmt_rsp_if;
    logic                                        valid;
    logic                                        ready;
    logic signed [rarmt_pkg::VALUE_W-1:0]        range_minimum;

    modport source (output valid, range_minimum, input ready);
    modport sink   (input valid, range_minimum, output ready);
endinterface

// ===== sv/rarmt_ram.sv =====
`timescale 1ns / 1ps

module rarmt_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/range_add_range_min_tree_core.sv =====
`timescale 1ns / 1ps
// A request walks the tree depth first, one node read and one node write a cycle. An empty
// span skips the walk: an add is finished on acceptance and a query goes straight to the
// done state. Only one request is handled at a time; ready stays low until the previous one
// is finished. Reset and every length write start a clearing pass over all 4 * MAX_ELEMENTS
// tree nodes, during which no request is taken; after it all elements read as zero.
module range_add_range_min_tree_core #(
    parameter int MAX_ELEMENTS = rarmt_pkg::MAX_ELEMENTS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [rarmt_pkg::LENGTH_W-1:0]   cfg_data,
    rarmt_req_if.sink                        req_ch,
    rarmt_rsp_if.source                      rsp_ch
);

    import rarmt_pkg::*;

    localparam int NODES = 4 * MAX_ELEMENTS;
    localparam int NB    = $clog2(NODES);
    localparam int LW    = $clog2(MAX_ELEMENTS);
    localparam int CW    = (LW > END_W) ? LW : END_W;
    localparam int SD    = LW + 1;
    localparam int SPW   = $clog2(SD + 1);
    localparam int SIW   = $clog2(SD);
    localparam int RW    = 2 * VALUE_W;

    state_t state_reg, state_next;

    // Walk stack of (node, lo, hi, phase).
    logic [NB-1:0] node_stk [SD];
    logic [LW-1:0] lo_stk   [SD];
    logic [LW-1:0] hi_stk   [SD];
    phase_t        ph_stk   [SD];
    logic [SPW-1:0] sp_reg;

    logic                       mode_reg;
    logic [CW-1:0]              ql_reg, qr_reg;
    logic signed [VALUE_W-1:0]  amt_reg, acc_reg, pend_reg, nmin_reg, lmin_reg;
    logic [LENGTH_W-1:0]        len_reg;
    logic [NB-1:0]              clr_cnt_reg;
    logic                       out_valid_reg;
    logic signed [VALUE_W-1:0]  out_min_reg;

    // Memory port.
    logic            ram_we;
    logic [NB-1:0]   ram_waddr, ram_raddr;
    logic [RW-1:0]   ram_wdata, ram_rdata;
    logic signed [VALUE_W-1:0] rmin, rpend;

    rarmt_ram #(
        .WIDTH(RW),
        .DEPTH(NODES)
    ) u_node_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign rmin  = ram_rdata[RW-1:VALUE_W];
    assign rpend = ram_rdata[VALUE_W-1:0];

    // Top of stack and its children.
    logic [SIW-1:0] top_idx, push_idx;
    logic [NB-1:0]  t_node, l_node, r_node;
    logic [LW-1:0]  t_lo, t_hi, t_mid;
    phase_t         t_ph;
    logic [LW:0]    lo_hi_sum;
    logic [CW-1:0]  lo_ext, hi_ext;
    logic           disjoint, covered;

    assign top_idx   = SIW'(sp_reg - 1'b1);
    assign push_idx  = SIW'(sp_reg);
    assign t_node    = node_stk[top_idx];
    assign t_lo      = lo_stk[top_idx];
    assign t_hi      = hi_stk[top_idx];
    assign t_ph      = ph_stk[top_idx];
    assign lo_hi_sum = {1'b0, t_lo} + {1'b0, t_hi};
    assign t_mid     = lo_hi_sum[LW:1];
    assign l_node    = {t_node[NB-2:0], 1'b0};
    assign r_node    = {t_node[NB-2:0], 1'b1};
    assign lo_ext    = CW'(t_lo);
    assign hi_ext    = CW'(t_hi);
    assign disjoint  = (qr_reg < lo_ext) || (hi_ext < ql_reg);
    assign covered   = (ql_reg <= lo_ext) && (hi_ext <= qr_reg);

    // Request decode: clip the span to the effective length.
    logic [CW-1:0] n_eff, end_clip, start_ext;
    logic          span_empty, accept;
    logic [LW-1:0] root_hi;

    always_comb
    begin
        priority if (len_reg == '0)
        begin
            n_eff = CW'(1);
        end
        else if (CW'(len_reg) > CW'(MAX_ELEMENTS))
        begin
            n_eff = CW'(MAX_ELEMENTS);
        end
        else
        begin
            n_eff = CW'(len_reg);
        end
    end

    assign start_ext  = CW'(req_ch.range_start);
    assign end_clip   = (CW'(req_ch.range_end) > n_eff) ? n_eff : CW'(req_ch.range_end);
    assign span_empty = start_ext >= end_clip;
    assign root_hi    = LW'(n_eff - 1'b1);
    assign accept     = req_ch.valid && req_ch.ready;
    assign req_ch.ready = (state_reg == ST_IDLE);

    logic last_frame;
    logic out_free;
    assign last_frame = (sp_reg == SPW'(1));
    assign out_free   = !out_valid_reg || rsp_ch.ready;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == NB'(NODES - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (span_empty)
                    begin
                        state_next = (req_ch.mode == MODE_QUERY) ? ST_DONE : ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_VISIT;
                    end
                end
            end
            ST_VISIT:
            begin
                unique case (t_ph)
                    PH_ENTER:
                    begin
                        if (disjoint)
                        begin
                            state_next = last_frame ? ((mode_reg == MODE_QUERY) ? ST_DONE
                                                                               : ST_IDLE)
                                                    : ST_VISIT;
                        end
                        else
                        begin
                            state_next = ST_NODE;
                        end
                    end
                    PH_RIGHT:
                    begin
                        state_next = ST_VISIT;
                    end
                    PH_JOIN:
                    begin
                        if (mode_reg == MODE_ADD)
                        begin
                            state_next = ST_CH_L;
                        end
                        else
                        begin
                            state_next = last_frame ? ST_DONE : ST_VISIT;
                        end
                    end
                    default:
                    begin
                        state_next = ST_VISIT;
                    end
                endcase
            end
            ST_NODE:
            begin
                if (covered)
                begin
                    state_next = last_frame ? ((mode_reg == MODE_QUERY) ? ST_DONE : ST_IDLE)
                                            : ST_VISIT;
                end
                else
                begin
                    state_next = ST_PD_L;
                end
            end
            ST_PD_L:
            begin
                state_next = ST_PD_R;
            end
            ST_PD_R:
            begin
                state_next = ST_PD_N;
            end
            ST_PD_N:
            begin
                state_next = ST_VISIT;
            end
            ST_CH_L:
            begin
                state_next = ST_CH_R;
            end
            ST_CH_R:
            begin
                state_next = last_frame ? ST_IDLE : ST_VISIT;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
        if (cfg_we)
        begin
            state_next = ST_CLEAR;
        end
    end

    // Memory and stack controls.
    logic           stk_push, stk_pop, ph_set, stk_init;
    phase_t         ph_val;
    logic [NB-1:0]  push_node;
    logic [LW-1:0]  push_lo, push_hi;
    logic           acc_take, save_node, save_left;
    logic signed [VALUE_W-1:0] child_min;

    assign child_min = (rmin < lmin_reg) ? rmin : lmin_reg;

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = t_node;
        ram_wdata = '0;
        ram_raddr = t_node;
        stk_push  = 1'b0;
        stk_pop   = 1'b0;
        stk_init  = 1'b0;
        ph_set    = 1'b0;
        ph_val    = PH_ENTER;
        push_node = l_node;
        push_lo   = t_lo;
        push_hi   = t_mid;
        acc_take  = 1'b0;
        save_node = 1'b0;
        save_left = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_cnt_reg;
            end
            ST_IDLE:
            begin
                stk_init = accept && !span_empty;
            end
            ST_VISIT:
            begin
                unique case (t_ph)
                    PH_ENTER:
                    begin
                        stk_pop = disjoint;
                    end
                    PH_RIGHT:
                    begin
                        stk_push  = 1'b1;
                        push_node = r_node;
                        push_lo   = LW'(t_mid + 1'b1);
                        push_hi   = t_hi;
                        ph_set    = 1'b1;
                        ph_val    = PH_JOIN;
                    end
                    PH_JOIN:
                    begin
                        ram_raddr = l_node;
                        stk_pop   = (mode_reg == MODE_QUERY);
                    end
                    default:
                    begin
                        stk_pop = 1'b0;
                    end
                endcase
            end
            ST_NODE:
            begin
                if (covered)
                begin
                    stk_pop = 1'b1;
                    if (mode_reg == MODE_ADD)
                    begin
                        ram_we    = 1'b1;
                        ram_wdata = {rmin + amt_reg, rpend + amt_reg};
                    end
                    else
                    begin
                        acc_take = 1'b1;
                    end
                end
                else
                begin
                    save_node = 1'b1;
                    ram_raddr = l_node;
                end
            end
            ST_PD_L:
            begin
                ram_we    = 1'b1;
                ram_waddr = l_node;
                ram_wdata = {rmin + pend_reg, rpend + pend_reg};
                ram_raddr = r_node;
            end
            ST_PD_R:
            begin
                ram_we    = 1'b1;
                ram_waddr = r_node;
                ram_wdata = {rmin + pend_reg, rpend + pend_reg};
            end
            ST_PD_N:
            begin
                ram_we    = 1'b1;
                ram_wdata = {nmin_reg, {VALUE_W{1'b0}}};
                ph_set    = 1'b1;
                ph_val    = PH_RIGHT;
                stk_push  = 1'b1;
            end
            ST_CH_L:
            begin
                save_left = 1'b1;
                ram_raddr = r_node;
            end
            ST_CH_R:
            begin
                ram_we    = 1'b1;
                ram_wdata = {child_min, {VALUE_W{1'b0}}};
                stk_pop   = 1'b1;
            end
            ST_DONE:
            begin
                stk_pop = 1'b0;
            end
            default:
            begin
                stk_pop = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            sp_reg        <= '0;
            clr_cnt_reg   <= '0;
            len_reg       <= LENGTH_W'(1024);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                len_reg     <= cfg_data;
                clr_cnt_reg <= '0;
            end
            else if (state_reg == ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (stk_init)
            begin
                sp_reg <= SPW'(1);
            end
            else if (stk_push)
            begin
                sp_reg <= sp_reg + 1'b1;
            end
            else if (stk_pop)
            begin
                sp_reg <= sp_reg - 1'b1;
            end
            if (state_reg == ST_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Stack and datapath registers.
    always_ff @(posedge clk)
    begin
        if (stk_init)
        begin
            node_stk[0] <= NB'(1);
            lo_stk[0]   <= '0;
            hi_stk[0]   <= root_hi;
            ph_stk[0]   <= PH_ENTER;
        end
        if (stk_push)
        begin
            node_stk[push_idx] <= push_node;
            lo_stk[push_idx]   <= push_lo;
            hi_stk[push_idx]   <= push_hi;
            ph_stk[push_idx]   <= PH_ENTER;
        end
        if (ph_set)
        begin
            ph_stk[top_idx] <= ph_val;
        end
        if (accept)
        begin
            mode_reg <= req_ch.mode;
            ql_reg   <= start_ext;
            qr_reg   <= end_clip - 1'b1;
            amt_reg  <= VALUE_W'(req_ch.add_amount);
            acc_reg  <= MOST_POSITIVE;
        end
        else if (acc_take && rmin < acc_reg)
        begin
            acc_reg <= rmin;
        end
        if (save_node)
        begin
            nmin_reg <= rmin;
            pend_reg <= rpend;
        end
        if (save_left)
        begin
            lmin_reg <= rmin;
        end
        if (state_reg == ST_DONE && out_free)
        begin
            out_min_reg <= acc_reg;
        end
    end

    assign rsp_ch.valid         = out_valid_reg;
    assign rsp_ch.range_minimum = out_min_reg;

    // The walk stack stays within its depth.
    assert property (@(posedge clk) disable iff (!rst_n) sp_reg <= SPW'(SD))
        else $error("walk stack overflow");

    // A length write always restarts the clearing pass.
    assert property (@(posedge clk) disable iff (!rst_n) cfg_we |=> state_reg == ST_CLEAR)
        else $error("length write did not start clearing");

    // The tree is only walked with a frame on the stack.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_VISIT || state_reg == ST_NODE) |-> sp_reg != '0)
        else $error("walk with empty stack");

    // A response is only produced from the done state.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_DONE)
        else $error("response outside done state");

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import rarmt_pkg::*;

    localparam int NODES = 4 * MAX_ELEMENTS_DEF;

    // One request as the driver holds it.
    typedef struct {
        logic                       mode;
        logic [START_W-1:0]         range_start;
        logic [END_W-1:0]           range_end;
        logic signed [AMOUNT_W-1:0] add_amount;
    } request_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [LENGTH_W-1:0] cfg_data;

    rarmt_req_if req_ch ();
    rarmt_rsp_if rsp_ch ();

    range_add_range_min_tree_core u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .req_ch   (req_ch),
        .rsp_ch   (rsp_ch)
    );

    // Mirror of the lazy tree and its length register.
    logic [VALUE_W-1:0] mirror_min  [NODES];
    logic [VALUE_W-1:0] mirror_pend [NODES];
    logic [LENGTH_W-1:0] mirror_length;

    request_t           pending_reqs [$];
    logic [VALUE_W-1:0] expected_mins [$];

    int  errors = 0;
    int  add_count = 0;
    int  query_count = 0;
    int  match_count = 0;
    int  length_writes = 0;
    bit  req_taken = 0;
    bit  quiet = 0;
    int  send_gap = 0;
    int  recv_gap = 0;
    int  recv_hold = 0;

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    task automatic report_mismatch(input string msg);
        errors++;
        $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    function automatic void mirror_clear();
        for (int i = 0; i < NODES; i++)
        begin
            mirror_min[i]  = '0;
            mirror_pend[i] = '0;
        end
    endfunction

    function automatic void node_apply(int node, logic [VALUE_W-1:0] amount);
        if (node >= NODES)
            return;
        mirror_pend[node] += amount;
        mirror_min[node]  += amount;
    endfunction

    function automatic void node_push(int node, int lo, int hi);
        if (lo == hi || node >= NODES)
            return;
        if (mirror_pend[node] != 0)
        begin
            node_apply(2 * node, mirror_pend[node]);
            node_apply(2 * node + 1, mirror_pend[node]);
            mirror_pend[node] = '0;
        end
    endfunction

    function automatic logic [VALUE_W-1:0] smin(logic [VALUE_W-1:0] a, logic [VALUE_W-1:0] b);
        return ($signed(b) < $signed(a)) ? b : a;
    endfunction

    function automatic void span_add(int node, int lo, int hi, int ql, int qr,
                                     logic [VALUE_W-1:0] amount);
        int mid;
        if (node >= NODES || qr < lo || hi < ql)
            return;
        if (ql <= lo && hi <= qr)
        begin
            node_apply(node, amount);
            return;
        end
        node_push(node, lo, hi);
        mid = (lo + hi) / 2;
        span_add(2 * node, lo, mid, ql, qr, amount);
        span_add(2 * node + 1, mid + 1, hi, ql, qr, amount);
        if (2 * node + 1 < NODES)
            mirror_min[node] = smin(mirror_min[2 * node], mirror_min[2 * node + 1]);
    endfunction

    function automatic logic [VALUE_W-1:0] span_min(int node, int lo, int hi, int ql, int qr);
        int mid;
        logic [VALUE_W-1:0] a;
        logic [VALUE_W-1:0] b;
        if (node >= NODES || qr < lo || hi < ql)
            return MOST_POSITIVE;
        if (ql <= lo && hi <= qr)
            return mirror_min[node];
        node_push(node, lo, hi);
        mid = (lo + hi) / 2;
        a = span_min(2 * node, lo, mid, ql, qr);
        b = span_min(2 * node + 1, mid + 1, hi, ql, qr);
        return smin(a, b);
    endfunction

    // Applies one accepted request to the mirror and queues the minimum a query yields.
    function automatic void predict_request(request_t r);
        int n;
        int s;
        int e;
        logic [VALUE_W-1:0] want;
        n = mirror_length;
        if (n < 1)
            n = 1;
        if (n > MAX_ELEMENTS_DEF)
            n = MAX_ELEMENTS_DEF;
        s = r.range_start;
        e = r.range_end;
        if (e > n)
            e = n;
        if (r.mode == MODE_ADD)
        begin
            add_count++;
            if (s < e)
                span_add(1, 0, n - 1, s, e - 1, VALUE_W'(r.add_amount));
        end
        else
        begin
            query_count++;
            want = (s < e) ? span_min(1, 0, n - 1, s, e - 1) : MOST_POSITIVE;
            expected_mins = {expected_mins, want};
        end
    endfunction

    // Request acceptance is seen at the rising edge.
    always @(posedge clk)
    begin
        request_t r;
        req_taken <= req_ch.valid && req_ch.ready;
        if (rst_n && req_ch.valid && req_ch.ready)
        begin
            r.mode        = req_ch.mode;
            r.range_start = req_ch.range_start;
            r.range_end   = req_ch.range_end;
            r.add_amount  = req_ch.add_amount;
            predict_request(r);
        end
    end

    // Request driver: moves at the falling edge, with random idle bursts.
    always @(negedge clk)
    begin
        request_t r;
        if (!req_ch.valid || req_taken)
        begin
            if (send_gap > 0)
            begin
                send_gap <= send_gap - 1;
                req_ch.valid <= 1'b0;
            end
            else if (!quiet && pending_reqs.size() != 0 && $urandom_range(0, 9) == 0)
            begin
                send_gap <= $urandom_range(0, 14);
                req_ch.valid <= 1'b0;
            end
            else if (pending_reqs.size() != 0)
            begin
                r = pending_reqs.pop_front();
                req_ch.valid       <= 1'b1;
                req_ch.mode        <= r.mode;
                req_ch.range_start <= r.range_start;
                req_ch.range_end   <= r.range_end;
                req_ch.add_amount  <= r.add_amount;
            end
            else
                req_ch.valid <= 1'b0;
        end
    end

    // Response ready: random stall bursts and the long hold-off.
    always @(negedge clk)
    begin
        if (recv_hold > 0)
        begin
            recv_hold <= recv_hold - 1;
            rsp_ch.ready <= 1'b0;
        end
        else if (recv_gap > 0)
        begin
            recv_gap <= recv_gap - 1;
            rsp_ch.ready <= 1'b0;
        end
        else if (!quiet && $urandom_range(0, 9) == 0)
        begin
            recv_gap <= $urandom_range(0, 14);
            rsp_ch.ready <= 1'b0;
        end
        else
            rsp_ch.ready <= 1'b1;
    end

    // Response checker.
    always @(posedge clk)
    begin
        logic [VALUE_W-1:0] want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (expected_mins.size() == 0)
                report_mismatch($sformatf("unexpected response %0d", rsp_ch.range_minimum));
            else
            begin
                want = expected_mins.pop_front();
                if (rsp_ch.range_minimum !== want)
                    report_mismatch($sformatf("range_minimum %0d, expected %0d",
                                              rsp_ch.range_minimum, $signed(want)));
                else
                    match_count++;
            end
        end
    end

    task automatic queue_request(input logic m, input int s, input int e, input int a);
        request_t r;
        r.mode        = m;
        r.range_start = START_W'(s);
        r.range_end   = END_W'(e);
        r.add_amount  = AMOUNT_W'(a);
        pending_reqs  = {pending_reqs, r};
    endtask

    // Random request, mostly aimed inside the active length.
    task automatic queue_random(input int len);
        int s;
        int e;
        int a;
        int top;
        top = (len < 1) ? 1 : ((len > MAX_ELEMENTS_DEF) ? MAX_ELEMENTS_DEF : len);
        if ($urandom_range(0, 9) < 8)
        begin
            s = $urandom_range(0, top - 1);
            e = $urandom_range(s, (top + 2 > MAX_ELEMENTS_DEF) ? MAX_ELEMENTS_DEF : top + 2);
        end
        else
        begin
            s = $urandom_range(0, MAX_ELEMENTS_DEF - 1);
            e = $urandom_range(0, MAX_ELEMENTS_DEF);
        end
        case ($urandom_range(0, 3))
            0: a = $urandom;
            1: a = $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
            default: a = $signed($urandom_range(0, 2000)) - 1000;
        endcase
        queue_request($urandom_range(0, 1), s, e, a);
    endtask

    // Waits until the driver is empty, every response is in, and the block has settled.
    task automatic drain();
        while (pending_reqs.size() != 0 || req_ch.valid || expected_mins.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic write_length(input int len);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= LENGTH_W'(len);
        @(negedge clk);
        cfg_we <= 1'b0;
        mirror_length = LENGTH_W'(len);
        mirror_clear();
        length_writes++;
    endtask

    initial
    begin
        int lengths [7];
        int counts  [7];
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        req_ch.valid = 1'b0;
        req_ch.mode = MODE_ADD;
        req_ch.range_start = '0;
        req_ch.range_end = '0;
        req_ch.add_amount = '0;
        rsp_ch.ready = 1'b0;
        mirror_length = LENGTH_W'(MAX_ELEMENTS_DEF);
        mirror_clear();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: zeros after reset, extreme amounts and empty spans.
        queue_request(MODE_QUERY, 0, 1024, 0);
        queue_request(MODE_ADD, 0, 1024, 32'h80000000);
        queue_request(MODE_ADD, 5, 6, 32'h7fffffff);
        queue_request(MODE_QUERY, 5, 6, 0);
        queue_request(MODE_QUERY, 0, 1024, 0);
        queue_request(MODE_QUERY, 10, 10, 0);
        queue_request(MODE_QUERY, 900, 300, 0);
        queue_request(MODE_ADD, 1023, 1024, 32'h7fffffff);
        queue_request(MODE_ADD, 1023, 1024, 32'h7fffffff);
        queue_request(MODE_QUERY, 1023, 1024, 0);
        queue_request(MODE_ADD, 512, 0, 32'h7fffffff);
        queue_request(MODE_QUERY, 0, 1, 0);
        queue_request(MODE_ADD, 0, 1024, 32'hffffffff);
        queue_request(MODE_QUERY, 511, 513, 0);
        queue_request(MODE_QUERY, 0, 1024, 0);
        drain();

        // Short length with a span running past the end.
        write_length(3);
        queue_request(MODE_ADD, 1, 1024, -7);
        queue_request(MODE_QUERY, 2, 1024, 0);
        queue_request(MODE_QUERY, 3, 1024, 0);
        queue_request(MODE_QUERY, 0, 1, 0);
        drain();

        // Random phases over several lengths; the first also holds off responses.
        lengths = '{1024, 1, 0, 2047, 7, 100, 1024};
        counts  = '{300, 100, 80, 200, 150, 150, 170};
        for (int p = 0; p < 7; p++)
        begin
            if (p != 0)
                write_length(lengths[p]);
            if (p == 6)
                quiet = 1;
            if (p == 0)
                recv_hold = 3000;
            for (int i = 0; i < counts[p]; i++)
                queue_random(lengths[p]);
            drain();
        end

        $display("Covered %0d adds and %0d queries (%0d responses checked)",
                 add_count, query_count, match_count);
        $display("across %0d length writes, stalls and a long response hold-off.",
                 length_writes);
        if (errors == 0 && expected_mins.size() == 0)
            $display("DONE: 0 errors");
        else
        begin
            if (expected_mins.size() != 0)
                report_mismatch($sformatf("%0d responses never arrived", expected_mins.size()));
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial
    begin
        #20ms;
        $display("Timeout with %0d requests and %0d responses outstanding.",
                 pending_reqs.size(), expected_mins.size());
        $display("DONE: errors detected");
        $finish;
    end

endmodule
